// ===== rtl/ssre_pkg.sv =====
package ssre_pkg;

   // block geometry
   localparam int BLOCK_BYTES = 512;
   localparam int RX_WINDOW   = 1036;
   localparam int WIN_W       = $clog2(RX_WINDOW + 1);
   localparam int DCNT_W      = $clog2(BLOCK_BYTES + 1);

   // command frame
   localparam int CMD_BYTES  = 7;
   localparam int STEP_W     = $clog2(CMD_BYTES);
   localparam int ADDR_SHIFT = 9;   // byte address = sector * 512

   localparam logic [7:0] FILL_BYTE      = 8'hFF;
   localparam logic [7:0] CMD_READ_BLOCK = 8'h51;
   localparam logic [7:0] TOKEN_BYTE     = 8'hFE;
   localparam logic [7:0] R1_FAIL_BITS   = 8'hFE;
   localparam logic [7:0] CRC_BYTE       = 8'h00;

   // action codes on the request side
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_RX    = 1'b1;

   // queue depth between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_R1    = 3'd1,
      PH_TOKEN = 3'd2,
      PH_DATA  = 3'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CMD    = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_R1    = 3'd1,
      ST_R1_ERR   = 3'd2,
      ST_NO_TOKEN = 3'd3,
      ST_SHORT    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      JOB_CMD         = 2'd0,
      JOB_DATA        = 2'd1,
      JOB_STATUS      = 2'd2,
      JOB_DATA_STATUS = 2'd3
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [31:0]  addr;
      logic [7:0]   data;
      logic         data_last;
      status_type   code;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== rtl/ssre_front.sv =====
module ssre_front import ssre_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,
   input  logic [23:0] req_tdata,
   input  q_stat_type  q_stat,
   output logic        push,
   output job_type     push_job
);

   phase_type          phase_ff, phase_in, phase_adv;
   logic [WIN_W-1:0]   win_ff, win_in, win_inc;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in, dcnt_inc;
   logic               sdhc_ff, sdhc_in;

   logic [15:0] sector;
   logic [7:0]  rx;
   logic        accept, is_start, is_rx;
   logic        r1_resp, r1_bad, token_hit, block_end, win_end;
   status_type  win_code;
   logic [31:0] addr;

   assign sector     = req_tdata[15:0];
   assign rx         = req_tdata[23:16];
   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign is_start   = accept && (req_tuser == ACT_START);
   assign is_rx      = accept && (req_tuser == ACT_RX) && (phase_ff != PH_IDLE);

   assign win_inc   = (win_ff < WIN_W'(RX_WINDOW)) ? win_ff + 1'b1 : win_ff;
   assign dcnt_inc  = dcnt_ff + 1'b1;
   assign r1_resp   = (rx != FILL_BYTE);
   assign r1_bad    = |(rx & R1_FAIL_BITS);
   assign token_hit = (rx == TOKEN_BYTE);
   assign block_end = (dcnt_inc >= DCNT_W'(BLOCK_BYTES));
   assign win_end   = (win_inc >= WIN_W'(RX_WINDOW));

   assign addr = sdhc_ff ? {16'b0, sector} : {(16 - ADDR_SHIFT)'(0), sector, ADDR_SHIFT'(0)};

   // parse step before the window check
   always_comb begin
      case (phase_ff)
         PH_R1:    phase_adv = r1_resp ? (r1_bad ? PH_IDLE : PH_TOKEN) : PH_R1;
         PH_TOKEN: phase_adv = token_hit ? PH_DATA : PH_TOKEN;
         PH_DATA:  phase_adv = block_end ? PH_IDLE : PH_DATA;
         default:  phase_adv = PH_IDLE;
      endcase
   end

   assign win_code = (phase_adv == PH_R1)    ? ST_NO_R1 :
                     (phase_adv == PH_TOKEN) ? ST_NO_TOKEN : ST_SHORT;

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (is_start) begin
         phase_in = PH_R1;
      end else if (is_rx) begin
         phase_in = (phase_adv != PH_IDLE && win_end) ? PH_IDLE : phase_adv;
      end
   end

   // outputs: one queue entry per transaction that yields results
   always_comb begin
      push               = 1'b0;
      push_job.kind      = JOB_STATUS;
      push_job.addr      = addr;
      push_job.data      = rx;
      push_job.data_last = 1'b0;
      push_job.code      = ST_OK;
      win_in             = win_ff;
      dcnt_in            = dcnt_ff;
      if (is_start) begin
         push          = 1'b1;
         push_job.kind = JOB_CMD;
         win_in        = '0;
         dcnt_in       = '0;
      end else if (is_rx) begin
         win_in = win_inc;
         case (phase_ff)
            PH_R1: begin
               if (r1_resp && r1_bad) begin
                  push          = 1'b1;
                  push_job.code = ST_R1_ERR;
               end else if (win_end) begin
                  push          = 1'b1;
                  push_job.code = win_code;
               end
            end
            PH_TOKEN: begin
               if (win_end) begin
                  push          = 1'b1;
                  push_job.code = win_code;
               end
            end
            PH_DATA: begin
               push    = 1'b1;
               dcnt_in = dcnt_inc;
               if (block_end) begin
                  push_job.kind      = JOB_DATA;
                  push_job.data_last = 1'b1;
               end else if (win_end) begin
                  push_job.kind = JOB_DATA_STATUS;
                  push_job.code = win_code;
               end else begin
                  push_job.kind = JOB_DATA;
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   assign sdhc_in = csr_we ? csr_wdata : sdhc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         win_ff   <= '0;
         dcnt_ff  <= '0;
         sdhc_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         win_ff   <= win_in;
         dcnt_ff  <= dcnt_in;
         sdhc_ff  <= sdhc_in;
      end
   end

endmodule

// ===== rtl/ssre_queue.sv =====
module ssre_queue import ssre_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  job_type    push_job,
   input  logic       pop,
   output job_type    head_job,
   output q_stat_type q_stat
);

   job_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign q_stat.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head_job     = mem_ff[rd_ff];

   assign wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/ssre_back.sv =====
module ssre_back import ssre_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  job_type     head_job,
   input  q_stat_type  q_stat,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   job_type           job_ff, job_in;
   logic              valid_ff, valid_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic                         fire, final_step, load;
   logic [CMD_BYTES-1:0][7:0]    cmd_bytes;
   logic [7:0]                   value;
   status_type                   status;
   kind_type                     kind;
   logic                         last;

   assign cmd_bytes = {CRC_BYTE, job_ff.addr[7:0], job_ff.addr[15:8], job_ff.addr[23:16],
                       job_ff.addr[31:24], CMD_READ_BLOCK, FILL_BYTE};

   always_comb begin
      case (job_ff.kind)
         JOB_CMD:         final_step = (step_ff == STEP_W'(CMD_BYTES - 1));
         JOB_DATA_STATUS: final_step = (step_ff != '0);
         default:         final_step = 1'b1;
      endcase
   end

   assign fire = valid_ff && rsp_tready;
   assign load = (!valid_ff || (fire && final_step)) && !q_stat.empty;
   assign pop  = load;

   always_comb begin
      job_in   = job_ff;
      valid_in = valid_ff;
      step_in  = step_ff;
      if (load) begin
         job_in   = head_job;
         valid_in = 1'b1;
         step_in  = '0;
      end else if (fire) begin
         if (final_step) begin
            valid_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   // result fields for the current step
   always_comb begin
      value  = 8'h00;
      status = ST_OK;
      kind   = KIND_STATUS;
      last   = 1'b1;
      case (job_ff.kind)
         JOB_CMD: begin
            kind  = KIND_CMD;
            value = cmd_bytes[step_ff];
            last  = final_step;
         end
         JOB_DATA: begin
            kind  = KIND_DATA;
            value = job_ff.data;
            last  = job_ff.data_last;
         end
         JOB_DATA_STATUS: begin
            if (step_ff == '0) begin
               kind  = KIND_DATA;
               value = job_ff.data;
               last  = 1'b0;
            end else begin
               status = job_ff.code;
            end
         end
         default: begin
            status = job_ff.code;
         end
      endcase
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'b0, status, value};
   assign rsp_tuser  = kind;
   assign rsp_tlast  = last;

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== rtl/sd_spi_sector_read_engine_top.sv =====
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tuser: action; tdata: sector, rx_byte
// rsp     | out | rsp_tvalid/rsp_tready | tuser: kind; tdata: value, status; tlast: last
// csr     | in  | csr_we                | csr_wdata: sdhc_mode
//
// a request transaction is taken every cycle while the four-entry job queue has room;
// the front parses one received byte per cycle while the queue has room (a compare and a counter update)
// the back drains one response per cycle while rsp_tready is high: a start yields seven, a byte at most two
// so sustained rate is one byte per cycle while rsp_tready stays high
// reset is synchronous, active high; no memory clearing pass is needed
// a stalled response side fills the queue and then drops req_tready
module sd_spi_sector_read_engine_top import ssre_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,     // sdhc_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,     // action
   input  logic [23:0] req_tdata,     // sector[15:0], rx_byte[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // value[7:0], status[10:8], zero fill
   output logic [1:0]  rsp_tuser,     // kind
   output logic        rsp_tlast
);

   q_stat_type q_stat;
   logic       push, pop;
   job_type    push_job, head_job;

   ssre_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .push       (push),
      .push_job   (push_job)
   );

   ssre_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_stat   (q_stat)
   );

   ssre_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== test/tb_sd_spi_sector_read_engine_top.sv =====
module tb_sd_spi_sector_read_engine_top;
   import ssre_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // how far a generated read runs before the next start
   localparam int STAGE_R1_WAIT = 0;
   localparam int STAGE_GAP     = 1;
   localparam int STAGE_DATA    = 2;

   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_PRINTS   = 40;

   typedef struct packed {
      logic        act;
      logic [15:0] sector;
      logic [7:0]  rx;
   } req_item_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  value;
      status_type  status;
      logic        last;
   } rsp_item_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic        csr_wdata  = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser  = 1'b0;
   logic [23:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   req_item_type pending_req[$];
   req_item_type next_req;
   rsp_item_type awaited_rsp[$];

   // predictor copy of the engine
   phase_type   read_phase   = PH_IDLE;
   int          window_used  = 0;
   int          data_seen    = 0;
   logic        block_addr   = 1'b0;

   int          mismatch_count = 0;
   int          tx_idle_pct    = 32;
   int          rx_idle_pct    = 60;
   int          hold_left      = 0;
   logic        hold_req       = 1'b0;

   sd_spi_sector_read_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void queue_rsp(kind_type k, logic [7:0] v, status_type s, logic l);
      rsp_item_type r;
      r.kind   = k;
      r.value  = v;
      r.status = s;
      r.last   = l;
      awaited_rsp.push_back(r);
   endfunction

   function automatic void predict_sector_read(logic act, logic [15:0] sec, logic [7:0] rx);
      logic [31:0] addr;
      status_type  code;
      if (act == ACT_START) begin
         addr = block_addr ? {16'd0, sec} : {7'd0, sec, 9'd0};
         queue_rsp(KIND_CMD, FILL_BYTE, ST_OK, 1'b0);
         queue_rsp(KIND_CMD, CMD_READ_BLOCK, ST_OK, 1'b0);
         queue_rsp(KIND_CMD, addr[31:24], ST_OK, 1'b0);
         queue_rsp(KIND_CMD, addr[23:16], ST_OK, 1'b0);
         queue_rsp(KIND_CMD, addr[15:8], ST_OK, 1'b0);
         queue_rsp(KIND_CMD, addr[7:0], ST_OK, 1'b0);
         queue_rsp(KIND_CMD, CRC_BYTE, ST_OK, 1'b1);
         read_phase  = PH_R1;
         window_used = 0;
         data_seen   = 0;
         return;
      end
      if (read_phase == PH_IDLE)
         return;
      if (window_used < RX_WINDOW)
         window_used++;
      case (read_phase)
         PH_R1: begin
            if (rx != FILL_BYTE) begin
               if ((rx & R1_FAIL_BITS) != 8'd0) begin
                  read_phase = PH_IDLE;
                  queue_rsp(KIND_STATUS, 8'd0, ST_R1_ERR, 1'b1);
                  return;
               end
               read_phase = PH_TOKEN;
            end
         end
         PH_TOKEN: begin
            if (rx == TOKEN_BYTE)
               read_phase = PH_DATA;
         end
         default: begin
            data_seen++;
            if (data_seen >= BLOCK_BYTES) begin
               read_phase = PH_IDLE;
               queue_rsp(KIND_DATA, rx, ST_OK, 1'b1);
               return;
            end
            queue_rsp(KIND_DATA, rx, ST_OK, 1'b0);
         end
      endcase
      if (window_used >= RX_WINDOW) begin
         code = (read_phase == PH_R1) ? ST_NO_R1 :
                (read_phase == PH_TOKEN) ? ST_NO_TOKEN : ST_SHORT;
         read_phase = PH_IDLE;
         queue_rsp(KIND_STATUS, 8'd0, code, 1'b1);
      end
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   task automatic check_rsp();
      rsp_item_type want;
      if (awaited_rsp.size() == 0) begin
         report_mismatch($sformatf("response with none pending: kind %0d value %02h",
                                   rsp_tuser, rsp_tdata[7:0]));
         return;
      end
      want = awaited_rsp.pop_front();
      if (rsp_tuser !== want.kind)
         report_mismatch($sformatf("kind %0d, want %0d", rsp_tuser, want.kind));
      if (rsp_tdata[7:0] !== want.value)
         report_mismatch($sformatf("value %02h, want %02h", rsp_tdata[7:0], want.value));
      if (rsp_tdata[10:8] !== want.status)
         report_mismatch($sformatf("status %0d, want %0d", rsp_tdata[10:8], want.status));
      if (rsp_tlast !== want.last)
         report_mismatch($sformatf("last %0b, want %0b", rsp_tlast, want.last));
   endtask

   // request driver: valid is held until the transaction goes through
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_req.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            next_req = pending_req.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_req.act;
            req_tdata  <= {next_req.rx, next_req.sector};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_req)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
   end

   // monitor: config writes, accepted requests, accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            block_addr = csr_wdata;
         if (req_tvalid && req_tready)
            predict_sector_read(req_tuser, req_tdata[15:0], req_tdata[23:16]);
         if (rsp_tvalid && rsp_tready)
            check_rsp();
      end
   end

   function automatic void add_start(logic [15:0] sec);
      req_item_type it;
      it.act    = ACT_START;
      it.sector = sec;
      it.rx     = 8'($urandom_range(255));
      pending_req.push_back(it);
   endfunction

   function automatic void add_rx(logic [7:0] b);
      req_item_type it;
      it.act    = ACT_RX;
      it.sector = 16'($urandom_range(16'hFFFF));
      it.rx     = b;
      pending_req.push_back(it);
   endfunction

   function automatic logic [7:0] rand_byte_except(logic [7:0] avoid);
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == avoid)
         b = ~avoid;
      return b;
   endfunction

   function automatic logic [15:0] pick_sector();
      int c;
      c = $urandom_range(9);
      if (c == 0)
         return 16'h0000;
      if (c == 1)
         return 16'hFFFF;
      return 16'($urandom_range(16'hFFFF));
   endfunction

   function automatic logic [7:0] good_r1();
      return 8'($urandom_range(1));
   endfunction

   function automatic void add_read(int stage, int fill_n, logic [7:0] r1, int gap_n, int data_n);
      add_start(pick_sector());
      repeat (fill_n) add_rx(FILL_BYTE);
      if (stage >= STAGE_GAP) begin
         add_rx(r1);
         repeat (gap_n) add_rx(rand_byte_except(TOKEN_BYTE));
      end
      if (stage >= STAGE_DATA) begin
         add_rx(TOKEN_BYTE);
         repeat (data_n) add_rx(8'($urandom_range(255)));
      end
   endfunction

   function automatic void add_random_reads(int count);
      int c;
      repeat (count) begin
         c = $urandom_range(99);
         if (c < 30)
            add_read(STAGE_DATA, $urandom_range(3), good_r1(), $urandom_range(3),
                     $urandom_range(1, 8));
         else if (c < 45)
            add_read(STAGE_GAP, $urandom_range(4), 8'($urandom_range(2, 254)),
                     $urandom_range(3), 0);
         else if (c < 65)
            add_read($urandom_range(STAGE_DATA), $urandom_range(3), good_r1(),
                     $urandom_range(3), $urandom_range(10));
         else if (c < 80)
            repeat ($urandom_range(1, 4)) add_rx(8'($urandom_range(255)));
         else begin
            add_start(pick_sector());
            repeat ($urandom_range(1, 10)) add_rx(8'($urandom_range(255)));
         end
      end
   endfunction

   task automatic write_addr_mode(logic mode);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_req.size() != 0 || req_tvalid)
         @(posedge clock);
      while (awaited_rsp.size() != 0)
         @(posedge clock);
      // idle a little before the next configuration write
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // byte addressing after reset
      add_rx(8'h00);
      add_rx(8'hFF);
      add_start(16'hFFFF);
      add_rx(FILL_BYTE);
      add_start(16'h0000);
      add_rx(8'h01);
      add_rx(8'h7F);
      add_rx(TOKEN_BYTE);
      add_rx(8'h00);
      add_rx(8'hFF);
      add_rx(TOKEN_BYTE);
      add_start(16'h8001);
      add_rx(8'h80);
      add_rx(8'h55);
      wait_drained();

      write_addr_mode(1'b1);
      add_start(16'hFFFF);
      add_rx(8'h00);
      add_rx(FILL_BYTE);
      add_start(16'h1234);
      add_rx(TOKEN_BYTE);
      add_start(16'hA5A5);
      add_rx(8'h02);
      wait_drained();

      write_addr_mode(1'b0);
      add_read(STAGE_DATA, 2, good_r1(), 3, 8);
      add_random_reads(5);
      wait_drained();

      tx_idle_pct = 60;
      rx_idle_pct = 32;
      write_addr_mode(1'b1);
      add_read(STAGE_DATA, 0, good_r1(), 0, 8);
      add_random_reads(5);
      wait_drained();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_addr_mode(1'b0);
      add_read(STAGE_DATA, 5, good_r1(), 6, 8);
      add_random_reads(5);
      // long response stall while requests keep coming
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      wait_drained();

      if (mismatch_count == 0)
         $display("sd_spi_sector_read_engine_top test passed");
      else
         $display("sd_spi_sector_read_engine_top test failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("sd_spi_sector_read_engine_top test failed");
      $finish;
   end

endmodule
